@@ rtl/sxc_pkg.sv @@
`default_nettype none
package sxc_pkg;

    localparam logic [7:0] SYX_START      = 8'hF0;
    localparam logic [7:0] SYX_END        = 8'hF7;
    localparam logic [6:0] SUM_MASK       = 7'h7F;
    localparam logic [7:0] MULTI_RESPONSE = 8'h64;

    // Byte positions within a message; the position count saturates at MIN_LEN.
    localparam logic [3:0] POS_START    = 4'd0;
    localparam logic [3:0] POS_ID_FIRST = 4'd1;
    localparam logic [3:0] POS_ID_LAST  = 4'd3;
    localparam logic [3:0] POS_MODEL    = 4'd4;
    localparam logic [3:0] POS_COMMAND  = 4'd5;
    localparam logic [3:0] POS_RESPONSE = 4'd6;
    localparam logic [3:0] MIN_LEN      = 4'd8;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_MANUFACTURER_ID = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODEL_MASK      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AWAITED_COMMAND = 2'd2;

    localparam logic [23:0] MANUFACTURER_ID_RESET = 24'h000174;
    localparam logic [31:0] MODEL_MASK_RESET      = 32'h000105FF;
    localparam logic [7:0]  AWAITED_COMMAND_RESET = 8'h7E;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_FRAMING  = 3'd2,
        ST_MANUF    = 3'd3,
        ST_MODEL    = 3'd4,
        ST_CHECKSUM = 3'd5
    } sxc_status_t;

    typedef struct packed {
        logic [23:0] manufacturer_id;
        logic [31:0] model_mask;
        logic [7:0]  awaited_command;
    } sxc_cfg_t;

    typedef struct packed {
        sxc_status_t status;
        logic [7:0]  model_byte;
        logic [7:0]  command_byte;
        logic [7:0]  response_byte;
        logic        is_ack;
    } sxc_result_t;

endpackage
`default_nettype wire

@@ rtl/sxc_if.sv @@
`default_nettype none
interface sxc_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       final_byte;

    modport source (output valid, output msg_byte, output final_byte, input ready);
    modport sink   (input valid, input msg_byte, input final_byte, output ready);
endinterface

interface sxc_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] model_byte;
    logic [7:0] command_byte;
    logic [7:0] response_byte;
    logic       is_ack;

    modport source (output valid, output status, output model_byte, output command_byte,
                    output response_byte, output is_ack, input ready);
    modport sink   (input valid, input status, input model_byte, input command_byte,
                    input response_byte, input is_ack, output ready);
endinterface

interface sxc_cfg_if;
    import sxc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/sxc_frame_eval.sv @@
`default_nettype none
module sxc_frame_eval (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire logic [7:0]          byte_in,
    input  wire logic                final_in,
    input  wire sxc_pkg::sxc_cfg_t   cfg,
    output sxc_pkg::sxc_result_t     result
);
    import sxc_pkg::*;

    logic [3:0]  position_reg, position_next;
    logic        start_seen_reg, start_seen_next;
    logic [23:0] id_bytes_reg, id_bytes_next;
    logic [7:0]  model_reg, model_next;
    logic [7:0]  command_reg, command_next;
    logic [7:0]  response_reg, response_next;
    logic [7:0]  xor_reg, xor_next;
    logic [7:0]  prev_reg, prev_next;

    logic        model_ok;
    sxc_status_t status;

    // Capture the current byte into its field before judging the message.
    always_comb
    begin
        start_seen_next = start_seen_reg;
        id_bytes_next   = id_bytes_reg;
        model_next      = model_reg;
        command_next    = command_reg;
        response_next   = response_reg;
        case (position_reg) inside
            POS_START:                  start_seen_next = (byte_in == SYX_START);
            [POS_ID_FIRST:POS_ID_LAST]: id_bytes_next   = {id_bytes_reg[15:0], byte_in};
            POS_MODEL:                  model_next      = byte_in;
            POS_COMMAND:                command_next    = byte_in;
            POS_RESPONSE:               response_next   = byte_in;
            default:                    ;
        endcase
    end

    always_comb
    begin
        model_ok = (model_next[7:5] == 3'd0) && cfg.model_mask[model_next[4:0]];
        if (position_reg < (MIN_LEN - 4'd1))
            status = ST_SHORT;
        else if (!start_seen_next || byte_in != SYX_END)
            status = ST_FRAMING;
        else if (id_bytes_next != cfg.manufacturer_id)
            status = ST_MANUF;
        else if (!model_ok)
            status = ST_MODEL;
        else if ({1'b0, xor_reg[6:0] & SUM_MASK} != prev_reg)
            status = ST_CHECKSUM;
        else
            status = ST_OK;

        result.status        = status;
        result.model_byte    = model_next;
        result.command_byte  = command_next;
        result.response_byte = response_next;
        result.is_ack        = (command_next == MULTI_RESPONSE)
                               && (response_next == cfg.awaited_command);
    end

    // Advance the running checksum one byte behind the stream.
    always_comb
    begin
        xor_next      = (position_reg != POS_START) ? (xor_reg ^ prev_reg) : xor_reg;
        prev_next     = byte_in;
        position_next = (position_reg < MIN_LEN) ? position_reg + 4'd1 : position_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg   <= '0;
            start_seen_reg <= 1'b0;
            id_bytes_reg   <= '0;
            model_reg      <= '0;
            command_reg    <= '0;
            response_reg   <= '0;
            xor_reg        <= '0;
            prev_reg       <= '0;
        end
        else if (step)
        begin
            if (final_in)
            begin
                position_reg   <= '0;
                start_seen_reg <= 1'b0;
                id_bytes_reg   <= '0;
                model_reg      <= '0;
                command_reg    <= '0;
                response_reg   <= '0;
                xor_reg        <= '0;
                prev_reg       <= '0;
            end
            else
            begin
                position_reg   <= position_next;
                start_seen_reg <= start_seen_next;
                id_bytes_reg   <= id_bytes_next;
                model_reg      <= model_next;
                command_reg    <= command_next;
                response_reg   <= response_next;
                xor_reg        <= xor_next;
                prev_reg       <= prev_next;
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/sysex_message_checker.sv @@
`default_nettype none
// System-exclusive message checker.
// msg: a stream of raw message bytes, one per transaction; final_byte marks the
//   last byte of a message. Each message yields exactly one transaction on res;
//   other bytes yield nothing.
// res: status (first failed check: length, framing, manufacturer, model,
//   checksum), the model, command and response bytes, and is_ack.
// cfg: register writes (0 manufacturer_id, 1 model_mask, 2 awaited_command),
//   always ready; write only while no message is in flight. Other indexes drop.
// Throughput: one byte per cycle, set by the per-byte compare and XOR update, while
//   res is not stalling a final byte (see Stall).
// Result path: a final byte passes the input register, then the result register.
// Stall: while res is stalled, non-final bytes keep flowing; a final byte
//   waits in the input register, and msg.ready drops behind it.
// Reset: clears the message state, the pipeline valids, and reloads the
//   register defaults.
module sysex_message_checker (
    input wire logic clk,
    input wire logic rst_n,
    sxc_msg_if.sink  msg,
    sxc_res_if.source res,
    sxc_cfg_if.sink  cfg
);
    import sxc_pkg::*;

    // Configuration registers.
    sxc_cfg_t    cfg_reg;

    // Input register.
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_final_reg;

    // Result register.
    logic        res_valid_reg;
    sxc_result_t res_reg;

    sxc_result_t eval_result;
    logic        advance;
    logic        res_load;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.manufacturer_id <= MANUFACTURER_ID_RESET;
            cfg_reg.model_mask      <= MODEL_MASK_RESET;
            cfg_reg.awaited_command <= AWAITED_COMMAND_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_MANUFACTURER_ID: cfg_reg.manufacturer_id <= cfg.data[23:0];
                REG_MODEL_MASK:      cfg_reg.model_mask      <= cfg.data[31:0];
                REG_AWAITED_COMMAND: cfg_reg.awaited_command <= cfg.data[7:0];
                default:             ;
            endcase
        end
    end

    // A non-final byte always advances; a final byte needs room in the result register.
    assign advance  = in_valid_reg && (!in_final_reg || !res_valid_reg || res.ready);
    assign res_load = advance && in_final_reg;
    assign msg.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (msg.ready)
            in_valid_reg <= msg.valid;
    end

    always_ff @(posedge clk)
    begin
        if (msg.valid && msg.ready)
        begin
            in_byte_reg  <= msg.msg_byte;
            in_final_reg <= msg.final_byte;
        end
    end

    sxc_frame_eval u_eval (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .byte_in  (in_byte_reg),
        .final_in (in_final_reg),
        .cfg      (cfg_reg),
        .result   (eval_result)
    );

    // Hold the result until taken; load the next one in the same cycle it leaves.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (res_load)
            res_valid_reg <= 1'b1;
        else if (res.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
            res_reg <= eval_result;
    end

    assign res.valid         = res_valid_reg;
    assign res.status        = res_reg.status;
    assign res.model_byte    = res_reg.model_byte;
    assign res.command_byte  = res_reg.command_byte;
    assign res.response_byte = res_reg.response_byte;
    assign res.is_ack        = res_reg.is_ack;

endmodule
`default_nettype wire
